>>> hdl/tlt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlt_pkg
// Shared types and constants of the target lock tracker.
// ----------------------------------------------------------------------------
package tlt_pkg;

  typedef enum logic [1:0] {
    MODE_LOST  = 2'd0,
    MODE_FOUND = 2'd1,
    MODE_DROP  = 2'd2
  } mode_e;

  localparam logic OP_LIGHT = 1'b0;
  localparam logic OP_EOF   = 1'b1;

  localparam int unsigned CFG_ADDR_BITS = 4;
  localparam int unsigned CFG_DATA_BITS = 32;

  localparam logic [1:0] REG_MIN_FOUND   = 2'd0;
  localparam logic [1:0] REG_LIMIT_FOUND = 2'd1;
  localparam logic [1:0] REG_LIMIT_DROP  = 2'd2;
  localparam logic [1:0] REG_MAX_DROP    = 2'd3;

  localparam logic [31:0] MIN_FOUND_RST   = 32'd100000;
  localparam logic [31:0] LIMIT_FOUND_RST = 32'd200000;
  localparam logic [31:0] LIMIT_DROP_RST  = 32'd1000000;
  localparam logic [31:0] MAX_DROP_RST    = 32'd500000;

endpackage

>>> hdl/tlt_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlt_if
// Valid/ready channels: candidate and end-of-frame words in, track words out.
// ----------------------------------------------------------------------------
interface tlt_in_if #(
  parameter int unsigned COORD_BITS = 12,
  parameter int unsigned SCORE_BITS = 16,
  parameter int unsigned TIME_BITS  = 24
);
  logic                  valid;
  logic                  ready;
  logic                  opcode;
  logic [COORD_BITS-1:0] light_x;
  logic [COORD_BITS-1:0] light_y;
  logic [SCORE_BITS-1:0] light_score;
  logic [TIME_BITS-1:0]  frame_interval;

  modport source (
    output valid, opcode, light_x, light_y, light_score, frame_interval,
    input  ready
  );
  modport sink (
    input  valid, opcode, light_x, light_y, light_score, frame_interval,
    output ready
  );
endinterface

interface tlt_out_if #(
  parameter int unsigned COORD_BITS = 12
);
  logic                  valid;
  logic                  ready;
  logic                  locked;
  logic [1:0]            track_mode;
  logic [COORD_BITS-1:0] target_x;
  logic [COORD_BITS-1:0] target_y;

  modport source (
    output valid, locked, track_mode, target_x, target_y,
    input  ready
  );
  modport sink (
    input  valid, locked, track_mode, target_x, target_y,
    output ready
  );
endinterface

>>> hdl/target_lock_tracker_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// target_lock_tracker_unit
// Per-frame light target selection and lock tracking.
// ----------------------------------------------------------------------------
// Feed each frame's light candidates, then one end-of-frame word carrying the
// frame interval in microseconds. Each input word lands in an input register,
// and from there a single pass of logic updates the frame's best-score and
// nearest candidate or, for an end-of-frame word, the track mode, accumulators
// and held position; mode and position go into the output register.
// Candidates give no output word; each end-of-frame word gives one, by way of
// the input and output registers. Input ready stays high at one word per cycle
// and drops only while an end-of-frame word waits behind an output word that
// has not been taken. Thresholds are to be written over APB only while the
// unit is idle; the unit itself does not enforce this.
module target_lock_tracker_unit
  import tlt_pkg::*;
#(
  parameter int unsigned COORD_BITS = 12,
  parameter int unsigned SCORE_BITS = 16,
  parameter int unsigned TIME_BITS  = 24
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  tlt_in_if.sink                   in_i,
  tlt_out_if.source                out_o,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [CFG_ADDR_BITS-1:0] paddr,
  input  logic [CFG_DATA_BITS-1:0] pwdata,
  output logic [CFG_DATA_BITS-1:0] prdata,
  output logic                     pready
);

  logic                  in_vld_q, op_q;
  logic [COORD_BITS-1:0] x_q, y_q;
  logic [SCORE_BITS-1:0] score_q;
  logic [TIME_BITS-1:0]  intv_q;
  logic                  in_rdy, advance, do_light, do_eof;

  logic                  out_vld_q, status_q;
  logic [1:0]            tmode_q;
  logic [COORD_BITS-1:0] tx_q, ty_q;

  logic [TIME_BITS-1:0]  min_found, limit_found, limit_drop, max_drop;
  logic                  has_light;
  logic [COORD_BITS-1:0] best_x, best_y, near_x, near_y;
  logic [COORD_BITS-1:0] held_x, held_y, held_x_d, held_y_d;
  mode_e                 mode_d;

  assign advance  = in_vld_q && ((op_q == OP_LIGHT) || !out_vld_q || out_o.ready);
  assign in_rdy   = !in_vld_q || advance;
  assign do_light = advance && (op_q == OP_LIGHT);
  assign do_eof   = advance && (op_q == OP_EOF);
  assign in_i.ready = in_rdy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_rdy) begin
      in_vld_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_rdy && in_i.valid) begin
      op_q    <= in_i.opcode;
      x_q     <= in_i.light_x;
      y_q     <= in_i.light_y;
      score_q <= in_i.light_score;
      intv_q  <= in_i.frame_interval;
    end
  end

  tlt_cfg_regs #(
    .TIME_BITS (TIME_BITS)
  ) u_cfg (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .min_found_o   (min_found),
    .limit_found_o (limit_found),
    .limit_drop_o  (limit_drop),
    .max_drop_o    (max_drop)
  );

  tlt_frame_acc #(
    .COORD_BITS (COORD_BITS),
    .SCORE_BITS (SCORE_BITS)
  ) u_frame (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .light_i     (do_light),
    .clear_i     (do_eof),
    .x_i         (x_q),
    .y_i         (y_q),
    .score_i     (score_q),
    .held_x_i    (held_x),
    .held_y_i    (held_y),
    .has_light_o (has_light),
    .best_x_o    (best_x),
    .best_y_o    (best_y),
    .near_x_o    (near_x),
    .near_y_o    (near_y)
  );

  tlt_track #(
    .COORD_BITS (COORD_BITS),
    .TIME_BITS  (TIME_BITS)
  ) u_track (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .eof_i         (do_eof),
    .interval_i    (intv_q),
    .min_found_i   (min_found),
    .limit_found_i (limit_found),
    .limit_drop_i  (limit_drop),
    .max_drop_i    (max_drop),
    .has_light_i   (has_light),
    .best_x_i      (best_x),
    .best_y_i      (best_y),
    .near_x_i      (near_x),
    .near_y_i      (near_y),
    .held_x_o      (held_x),
    .held_y_o      (held_y),
    .mode_d_o      (mode_d),
    .held_x_d_o    (held_x_d),
    .held_y_d_o    (held_y_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (do_eof) begin
      out_vld_q <= 1'b1;
    end else if (out_o.ready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_eof) begin
      status_q <= (mode_d != MODE_LOST);
      tmode_q  <= mode_d;
      tx_q     <= held_x_d;
      ty_q     <= held_y_d;
    end
  end

  assign out_o.valid      = out_vld_q;
  assign out_o.locked     = status_q;
  assign out_o.track_mode = tmode_q;
  assign out_o.target_x   = tx_q;
  assign out_o.target_y   = ty_q;

endmodule

>>> hdl/tlt_cfg_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlt_cfg_regs
// APB register file holding the four time thresholds.
// ----------------------------------------------------------------------------
module tlt_cfg_regs
  import tlt_pkg::*;
#(
  parameter int unsigned TIME_BITS = 24
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [CFG_ADDR_BITS-1:0] paddr,
  input  logic [CFG_DATA_BITS-1:0] pwdata,
  output logic [CFG_DATA_BITS-1:0] prdata,
  output logic                     pready,
  output logic [TIME_BITS-1:0]     min_found_o,
  output logic [TIME_BITS-1:0]     limit_found_o,
  output logic [TIME_BITS-1:0]     limit_drop_o,
  output logic [TIME_BITS-1:0]     max_drop_o
);

  logic [TIME_BITS-1:0] min_found_q, limit_found_q, limit_drop_q, max_drop_q;
  logic [TIME_BITS-1:0] rd_val;
  logic [1:0]           idx;
  logic                 wr_en;

  assign idx    = paddr[3:2];
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_found_q   <= MIN_FOUND_RST[TIME_BITS-1:0];
      limit_found_q <= LIMIT_FOUND_RST[TIME_BITS-1:0];
      limit_drop_q  <= LIMIT_DROP_RST[TIME_BITS-1:0];
      max_drop_q    <= MAX_DROP_RST[TIME_BITS-1:0];
    end else if (wr_en) begin
      case (idx)
        REG_MIN_FOUND:   min_found_q   <= pwdata[TIME_BITS-1:0];
        REG_LIMIT_FOUND: limit_found_q <= pwdata[TIME_BITS-1:0];
        REG_LIMIT_DROP:  limit_drop_q  <= pwdata[TIME_BITS-1:0];
        REG_MAX_DROP:    max_drop_q    <= pwdata[TIME_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_MIN_FOUND:   rd_val = min_found_q;
      REG_LIMIT_FOUND: rd_val = limit_found_q;
      REG_LIMIT_DROP:  rd_val = limit_drop_q;
      REG_MAX_DROP:    rd_val = max_drop_q;
      default:         rd_val = '0;
    endcase
  end

  assign prdata        = CFG_DATA_BITS'(rd_val);
  assign min_found_o   = min_found_q;
  assign limit_found_o = limit_found_q;
  assign limit_drop_o  = limit_drop_q;
  assign max_drop_o    = max_drop_q;

endmodule

>>> hdl/tlt_frame_acc.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlt_frame_acc
// Running best-score and nearest-to-held candidate of the current frame.
// ----------------------------------------------------------------------------
module tlt_frame_acc
  import tlt_pkg::*;
#(
  parameter int unsigned COORD_BITS = 12,
  parameter int unsigned SCORE_BITS = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  light_i,
  input  logic                  clear_i,
  input  logic [COORD_BITS-1:0] x_i,
  input  logic [COORD_BITS-1:0] y_i,
  input  logic [SCORE_BITS-1:0] score_i,
  input  logic [COORD_BITS-1:0] held_x_i,
  input  logic [COORD_BITS-1:0] held_y_i,
  output logic                  has_light_o,
  output logic [COORD_BITS-1:0] best_x_o,
  output logic [COORD_BITS-1:0] best_y_o,
  output logic [COORD_BITS-1:0] near_x_o,
  output logic [COORD_BITS-1:0] near_y_o
);

  localparam int unsigned DIST_BITS = 2 * COORD_BITS + 1;

  logic                  has_q;
  logic [SCORE_BITS-1:0] best_sc_q;
  logic [COORD_BITS-1:0] best_x_q, best_y_q, near_x_q, near_y_q;
  logic [DIST_BITS-1:0]  near_d_q;
  logic [COORD_BITS-1:0] dx, dy;
  logic [DIST_BITS-1:0]  sq_dist;
  logic                  take_best, take_near;

  assign dx      = (x_i > held_x_i) ? (x_i - held_x_i) : (held_x_i - x_i);
  assign dy      = (y_i > held_y_i) ? (y_i - held_y_i) : (held_y_i - y_i);
  assign sq_dist = DIST_BITS'(dx) * DIST_BITS'(dx) + DIST_BITS'(dy) * DIST_BITS'(dy);

  assign take_best = score_i > best_sc_q;
  assign take_near = !has_q || (sq_dist < near_d_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      has_q     <= 1'b0;
      best_sc_q <= '0;
      best_x_q  <= '0;
      best_y_q  <= '0;
      near_d_q  <= '1;
      near_x_q  <= '0;
      near_y_q  <= '0;
    end else if (clear_i) begin
      has_q     <= 1'b0;
      best_sc_q <= '0;
      best_x_q  <= '0;
      best_y_q  <= '0;
      near_d_q  <= '1;
      near_x_q  <= '0;
      near_y_q  <= '0;
    end else if (light_i) begin
      has_q <= 1'b1;
      if (take_best) begin
        best_sc_q <= score_i;
        best_x_q  <= x_i;
        best_y_q  <= y_i;
      end
      if (take_near) begin
        near_d_q <= sq_dist;
        near_x_q <= x_i;
        near_y_q <= y_i;
      end
    end
  end

  assign has_light_o = has_q;
  assign best_x_o    = best_x_q;
  assign best_y_o    = best_y_q;
  assign near_x_o    = near_x_q;
  assign near_y_o    = near_y_q;

endmodule

>>> hdl/tlt_track.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlt_track
// Lost/found/drop mode, time accumulators and held target position.
// ----------------------------------------------------------------------------
module tlt_track
  import tlt_pkg::*;
#(
  parameter int unsigned COORD_BITS = 12,
  parameter int unsigned TIME_BITS  = 24
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  eof_i,
  input  logic [TIME_BITS-1:0]  interval_i,
  input  logic [TIME_BITS-1:0]  min_found_i,
  input  logic [TIME_BITS-1:0]  limit_found_i,
  input  logic [TIME_BITS-1:0]  limit_drop_i,
  input  logic [TIME_BITS-1:0]  max_drop_i,
  input  logic                  has_light_i,
  input  logic [COORD_BITS-1:0] best_x_i,
  input  logic [COORD_BITS-1:0] best_y_i,
  input  logic [COORD_BITS-1:0] near_x_i,
  input  logic [COORD_BITS-1:0] near_y_i,
  output logic [COORD_BITS-1:0] held_x_o,
  output logic [COORD_BITS-1:0] held_y_o,
  output mode_e                 mode_d_o,
  output logic [COORD_BITS-1:0] held_x_d_o,
  output logic [COORD_BITS-1:0] held_y_d_o
);

  mode_e                 mode_q, mode_d;
  logic [TIME_BITS-1:0]  found_q, found_d, drop_q, drop_d;
  logic [TIME_BITS-1:0]  found_step, drop_step;
  logic [COORD_BITS-1:0] held_x_q, held_x_d, held_y_q, held_y_d;

  // saturating accumulate, pinned at limit once reached
  function automatic logic [TIME_BITS-1:0] acc_step(
    input logic [TIME_BITS-1:0] acc,
    input logic [TIME_BITS-1:0] plus,
    input logic [TIME_BITS-1:0] limit
  );
    logic [TIME_BITS:0] s;
    s = {1'b0, acc} + {1'b0, plus};
    if (acc >= limit) begin
      return limit;
    end else if (s[TIME_BITS]) begin
      return '1;
    end else begin
      return s[TIME_BITS-1:0];
    end
  endfunction

  assign found_step = acc_step(found_q, interval_i, limit_found_i);
  assign drop_step  = acc_step(drop_q, interval_i, limit_drop_i);

  always_comb begin
    mode_d   = mode_q;
    found_d  = found_q;
    drop_d   = drop_q;
    held_x_d = held_x_q;
    held_y_d = held_y_q;
    if (mode_q == MODE_LOST) begin
      drop_d = '0;
      if (has_light_i) begin
        found_d = found_step;
        if (found_step >= min_found_i) begin
          mode_d   = MODE_FOUND;
          held_x_d = best_x_i;
          held_y_d = best_y_i;
        end
      end else begin
        found_d = '0;
      end
    end else if (has_light_i) begin
      mode_d   = MODE_FOUND;
      drop_d   = '0;
      found_d  = found_step;
      held_x_d = near_x_i;
      held_y_d = near_y_i;
    end else begin
      mode_d  = MODE_DROP;
      found_d = '0;
      drop_d  = drop_step;
    end
    if (drop_d >= max_drop_i) begin
      mode_d   = MODE_LOST;
      found_d  = '0;
      drop_d   = '0;
      held_x_d = '0;
      held_y_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= MODE_LOST;
      found_q  <= '0;
      drop_q   <= '0;
      held_x_q <= '0;
      held_y_q <= '0;
    end else if (eof_i) begin
      mode_q   <= mode_d;
      found_q  <= found_d;
      drop_q   <= drop_d;
      held_x_q <= held_x_d;
      held_y_q <= held_y_d;
    end
  end

  assign held_x_o   = held_x_q;
  assign held_y_o   = held_y_q;
  assign mode_d_o   = mode_d;
  assign held_x_d_o = held_x_d;
  assign held_y_d_o = held_y_d;

endmodule
